// ----- hdl/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, character codes, mode and register codes for the text
// console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int MODE_W    = 2;
  localparam int CODE_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = 16;
  localparam int LOC_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int TAB_STEP  = 8;

  // item modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_ATTR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR = 1'b1;

  localparam logic [ATTR_W-1:0] CHAR_ATTR_RST  = 8'h0E;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h0F;

  // character codes
  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_DEL   = 8'h7F;

  // what a put does beyond moving the cursor
  typedef struct packed {
    logic write_cell;
    logic scroll;
  } put_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCROLL = 4'b0010,
    ST_CLEAR  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

endpackage

// ----- hdl/tcw_screen_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
  parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = tcw_pkg::CELL_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/tcw_cursor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cursor
// Next cursor position for a put: control codes, printable advance, right
// edge wrap and bottom overflow detection.
// ----------------------------------------------------------------------------
module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int COL_W   = $clog2(COLUMNS),
  parameter int ROW_W   = $clog2(ROWS),
  parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
  input  logic [COL_W-1:0]            col,
  input  logic [ROW_W-1:0]            row,
  input  logic [tcw_pkg::CODE_W-1:0]  code,
  output logic [COL_W-1:0]            col_nxt,
  output logic [ROW_W-1:0]            row_nxt,
  output logic [ADDR_W-1:0]           pos_nxt,
  output tcw_pkg::put_ctl_t           ctl
);

  // one spare bit each for tab overshoot and row overflow
  logic [COL_W:0] col_x;
  logic [ROW_W:0] row_x;

  always_comb begin
    col_x = {1'b0, col};
    row_x = {1'b0, row};
    ctl   = '0;
    case (code)
      tcw_pkg::CH_BS: begin
        if (col != '0) begin
          col_x = col_x - 1'b1;
        end
      end
      tcw_pkg::CH_TAB: begin
        col_x = (col_x + (COL_W+1)'(tcw_pkg::TAB_STEP))
              & ~(COL_W+1)'(tcw_pkg::TAB_STEP - 1);
      end
      tcw_pkg::CH_CR: begin
        col_x = '0;
      end
      tcw_pkg::CH_LF: begin
        col_x = '0;
        row_x = row_x + 1'b1;
      end
      default: begin
        if (code inside {[tcw_pkg::CH_SPACE:tcw_pkg::CH_DEL]}) begin
          ctl.write_cell = 1'b1;
          col_x          = col_x + 1'b1;
        end
      end
    endcase
    if (col_x >= (COL_W+1)'(COLUMNS)) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
    if (row_x >= (ROW_W+1)'(ROWS)) begin
      ctl.scroll = 1'b1;
      row_x      = (ROW_W+1)'(ROWS - 1);
    end
  end

  assign col_nxt = col_x[COL_W-1:0];
  assign row_nxt = row_x[ROW_W-1:0];
  assign pos_nxt = ADDR_W'(row_nxt) * ADDR_W'(COLUMNS) + ADDR_W'(col_nxt);

endmodule

// ----- hdl/text_console_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen cell memory, cursor and item sequencer.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A put, a read or an unused mode goes
// to the result state and then into the output register once that is free. A
// put that runs past the bottom row scrolls the screen through the memory, one
// cell per cycle on its single write port. A clear writes every cell once, one
// per cycle. The screen memory gets no pass after reset: its contents are
// undefined until the first clear. The input is stalled while an item is in
// work; a finished result waits in the output register while the next item is
// already taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcw_pkg::MODE_W-1:0]    in_mode,
  input  logic [tcw_pkg::CODE_W-1:0]    in_char_code,
  input  logic [tcw_pkg::LOC_W-1:0]     in_cell_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcw_pkg::LOC_W-1:0]     out_cursor_location,
  output logic [tcw_pkg::CELL_W-1:0]    out_read_data,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  tcw_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [COL_W-1:0]  cursor_col_r, cursor_col_nxt;
  logic [ROW_W-1:0]  cursor_row_r, cursor_row_nxt;
  logic [ADDR_W-1:0] cursor_pos_r, cursor_pos_nxt;
  logic              read_hit_r, read_hit_nxt;
  logic [tcw_pkg::ATTR_W-1:0] char_attr_r, blank_attr_r;

  logic                          out_valid_r;
  logic [tcw_pkg::LOC_W-1:0]     out_loc_r;
  logic [tcw_pkg::CELL_W-1:0]    out_data_r;

  logic                          ram_we, ram_re;
  logic [ADDR_W-1:0]             ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;
  logic [tcw_pkg::CELL_W-1:0]    blank_cell;

  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;
  logic [ADDR_W-1:0] put_pos;
  tcw_pkg::put_ctl_t put_ctl;

  logic result_go;

  tcw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W),
    .DATA_W (tcw_pkg::CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .COL_W   (COL_W),
    .ROW_W   (ROW_W),
    .ADDR_W  (ADDR_W)
  ) u_cursor (
    .col     (cursor_col_r),
    .row     (cursor_row_r),
    .code    (in_char_code),
    .col_nxt (put_col),
    .row_nxt (put_row),
    .pos_nxt (put_pos),
    .ctl     (put_ctl)
  );

  assign blank_cell = {blank_attr_r, tcw_pkg::CH_SPACE};
  assign in_stall   = (state_r != tcw_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign result_go  = (state_r == tcw_pkg::ST_RESULT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    cursor_pos_nxt = cursor_pos_r;
    read_hit_nxt   = read_hit_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = blank_cell;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (in_valid) begin
          read_hit_nxt = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = tcw_pkg::ST_RESULT;
          case (in_mode)
            tcw_pkg::MODE_PUT: begin
              cursor_col_nxt = put_col;
              cursor_row_nxt = put_row;
              cursor_pos_nxt = put_pos;
              if (put_ctl.write_cell) begin
                ram_we    = 1'b1;
                ram_waddr = cursor_pos_r;
                ram_wdata = {char_attr_r, in_char_code};
              end
              if (put_ctl.scroll) begin
                state_nxt = tcw_pkg::ST_SCROLL;
              end
            end
            tcw_pkg::MODE_CLEAR: begin
              cursor_col_nxt = '0;
              cursor_row_nxt = '0;
              cursor_pos_nxt = '0;
              state_nxt      = tcw_pkg::ST_CLEAR;
            end
            tcw_pkg::MODE_READ: begin
              if (32'(in_cell_index) < 32'(CELLS)) begin
                ram_re       = 1'b1;
                ram_raddr    = ADDR_W'(in_cell_index);
                read_hit_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // step k reads cell k+COLUMNS and writes cell k-1 with last read, or a blank in the last row
        if (cnt_r < CNT_W'(CELLS - COLUMNS)) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(cnt_r + CNT_W'(COLUMNS));
        end
        if (cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(cnt_r - 1'b1);
          ram_wdata = (cnt_r <= CNT_W'(CELLS - COLUMNS)) ? ram_rdata : blank_cell;
        end
        if (cnt_r == CNT_W'(CELLS)) begin
          state_nxt = tcw_pkg::ST_RESULT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(cnt_r);
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          state_nxt = tcw_pkg::ST_RESULT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcw_pkg::ST_RESULT: begin
        if (result_go) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcw_pkg::ST_IDLE;
      cnt_r        <= '0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      cursor_pos_r <= '0;
      read_hit_r   <= 1'b0;
      char_attr_r  <= tcw_pkg::CHAR_ATTR_RST;
      blank_attr_r <= tcw_pkg::BLANK_ATTR_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      cursor_pos_r <= cursor_pos_nxt;
      read_hit_r   <= read_hit_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcw_pkg::CFG_CHAR_ATTR:  char_attr_r  <= cfg_data;
          tcw_pkg::CFG_BLANK_ATTR: blank_attr_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (result_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (result_go) begin
      out_loc_r  <= tcw_pkg::LOC_W'(cursor_pos_r);
      out_data_r <= read_hit_r ? ram_rdata : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_location = out_loc_r;
  assign out_read_data       = out_data_r;

`ifndef SYNTH
  // a new result beat only comes out of the result state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tcw_pkg::ST_RESULT))
    else $error("result beat raised outside result state");

  // scroll copy never reads the cell it writes in the same cycle
  a_scroll_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("screen memory read and write collide");

  // a scroll always leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_SCROLL) |->
      (cursor_row_r == ROW_W'(ROWS - 1)) && (cursor_col_r == '0))
    else $error("cursor not on last row during scroll");

  // linear cursor position tracks row and column
  a_cursor_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_pos_r == ADDR_W'(cursor_row_r) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col_r))
    else $error("cursor position out of step with row and column");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the text console writer against its own screen and cursor image.
// A short scripted opening covers reset values, the extremes of the fields,
// every mode and the cursor corner cases. Random runs of text lines, line
// feeds, tab runs, reads and noise then follow, which drive the cursor past
// the right edge and the bottom row many times. Each run uses its own
// attribute settings and its own pattern of idle cycles on the two channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COLUMNS      = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS         = tcw_pkg::ROWS_DEF;
  localparam int CELLS        = COLUMNS * ROWS;
  localparam int CELL_AW      = $clog2(CELLS);
  localparam int LOC_MAX      = 2 ** tcw_pkg::LOC_W - 1;
  localparam int PHASE_ITEMS  = 140;
  localparam int MAX_CYCLES   = 5_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int OPENING_ROWS = 25;
  localparam int SCRIPT_AW    = $clog2(OPENING_ROWS);

  // mode value the block leaves unused
  localparam logic [tcw_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [tcw_pkg::LOC_W-1:0]  loc;
    logic [tcw_pkg::CELL_W-1:0] data;
  } cell_report_t;

  typedef struct packed {
    logic [tcw_pkg::MODE_W-1:0] mode;
    logic [tcw_pkg::CODE_W-1:0] code;
    logic [tcw_pkg::LOC_W-1:0]  idx;
    logic                       typed;
    logic [tcw_pkg::LOC_W-1:0]  loc;
    logic [tcw_pkg::CELL_W-1:0] data;
  } script_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [tcw_pkg::MODE_W-1:0]    in_mode;
  logic [tcw_pkg::CODE_W-1:0]    in_char_code;
  logic [tcw_pkg::LOC_W-1:0]     in_cell_index;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [tcw_pkg::LOC_W-1:0]     out_cursor_location;
  logic [tcw_pkg::CELL_W-1:0]    out_read_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tcw_pkg::ATTR_W-1:0]    cfg_data;

  // screen and cursor image
  logic [tcw_pkg::CELL_W-1:0] screen_image [CELLS];
  int                         cur_col = 0;
  int                         cur_row = 0;
  logic [tcw_pkg::ATTR_W-1:0] text_attr = tcw_pkg::CHAR_ATTR_RST;
  logic [tcw_pkg::ATTR_W-1:0] fill_attr = tcw_pkg::BLANK_ATTR_RST;

  cell_report_t due_reports [$];
  int           items_taken   = 0;
  int           mismatches    = 0;
  int           cycles        = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  // opening script: expected values typed in where they are plain
  script_row_t opening_script [OPENING_ROWS] = '{
    '{MODE_SPARE,          8'h00,             11'd0,    1'b1, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_READ,  8'h00,             11'd2047, 1'b1, 11'd0,  16'h0000},
    // 'H' before any clear
    '{tcw_pkg::MODE_PUT,   8'h48,             11'd0,    1'b1, 11'd1,  16'h0000},
    '{tcw_pkg::MODE_READ,  8'h00,             11'd0,    1'b1, 11'd1,  16'h0E48},
    '{tcw_pkg::MODE_PUT,   tcw_pkg::CH_BS,    11'd0,    1'b1, 11'd0,  16'h0000},
    // already at column 0
    '{tcw_pkg::MODE_PUT,   tcw_pkg::CH_BS,    11'd0,    1'b1, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_CLEAR, 8'hFF,             11'h7FF,  1'b1, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_READ,  8'h00,             11'd1999, 1'b1, 11'd0,  16'h0F20},
    // first address off screen
    '{tcw_pkg::MODE_READ,  8'h00,             11'd2000, 1'b1, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_PUT,   8'h00,             11'd0,    1'b1, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_PUT,   8'h1F,             11'd0,    1'b1, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_PUT,   8'h80,             11'd0,    1'b1, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_PUT,   8'hFF,             11'h7FF,  1'b1, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_PUT,   tcw_pkg::CH_SPACE, 11'd0,    1'b1, 11'd1,  16'h0000},
    '{tcw_pkg::MODE_PUT,   tcw_pkg::CH_DEL,   11'd0,    1'b1, 11'd2,  16'h0000},
    '{tcw_pkg::MODE_READ,  8'h00,             11'd1,    1'b1, 11'd2,  16'h0E7F},
    '{tcw_pkg::MODE_PUT,   tcw_pkg::CH_TAB,   11'd0,    1'b1, 11'd8,  16'h0000},
    '{tcw_pkg::MODE_PUT,   tcw_pkg::CH_TAB,   11'd0,    1'b1, 11'd16, 16'h0000},
    '{tcw_pkg::MODE_PUT,   tcw_pkg::CH_CR,    11'd0,    1'b1, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_PUT,   tcw_pkg::CH_LF,    11'd0,    1'b1, 11'd80, 16'h0000},
    '{tcw_pkg::MODE_PUT,   8'h7E,             11'h7FF,  1'b0, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_READ,  8'hFF,             11'd80,   1'b0, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_PUT,   tcw_pkg::CH_LF,    11'd0,    1'b0, 11'd0,  16'h0000},
    '{MODE_SPARE,          8'hFF,             11'h7FF,  1'b0, 11'd0,  16'h0000},
    '{tcw_pkg::MODE_READ,  8'h00,             11'd1919, 1'b0, 11'd0,  16'h0000}
  };

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cursor_location(out_cursor_location),
    .out_read_data      (out_read_data),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // updates the screen image for one item and returns its result
  function automatic cell_report_t apply_console_item(
      input logic [tcw_pkg::MODE_W-1:0] mode,
      input logic [tcw_pkg::CODE_W-1:0] code,
      input logic [tcw_pkg::LOC_W-1:0]  idx);
    cell_report_t rep;
    int i;
    rep.data = '0;
    case (mode)
      tcw_pkg::MODE_PUT: begin
        if (code == tcw_pkg::CH_BS && cur_col != 0) cur_col--;
        else if (code == tcw_pkg::CH_TAB)
          cur_col = (cur_col + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1);
        else if (code == tcw_pkg::CH_CR) cur_col = 0;
        else if (code == tcw_pkg::CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (code >= tcw_pkg::CH_SPACE && code <= tcw_pkg::CH_DEL) begin
          screen_image[CELL_AW'(cur_row * COLUMNS + cur_col)] = {text_attr, code};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++)
            screen_image[CELL_AW'(i)] = screen_image[CELL_AW'(i + COLUMNS)];
          for (i = CELLS - COLUMNS; i < CELLS; i++)
            screen_image[CELL_AW'(i)] = {fill_attr, tcw_pkg::CH_SPACE};
          cur_row = ROWS - 1;
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_image[CELL_AW'(i)] = {fill_attr, tcw_pkg::CH_SPACE};
        cur_col = 0;
        cur_row = 0;
      end
      tcw_pkg::MODE_READ: begin
        if (idx < CELLS) rep.data = screen_image[idx];
      end
      default: ;
    endcase
    rep.loc = tcw_pkg::LOC_W'(cur_row * COLUMNS + cur_col);
    return rep;
  endfunction

  // called and left at a falling edge; valid stays up for a following beat
  task automatic push_item(input logic [tcw_pkg::MODE_W-1:0] mode,
                           input logic [tcw_pkg::CODE_W-1:0] code,
                           input logic [tcw_pkg::LOC_W-1:0] idx, input logic typed,
                           input cell_report_t typed_report);
    cell_report_t forecast;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_char_code  <= code;
    in_cell_index <= idx;
    do @(posedge clk); while (in_stall);
    forecast = apply_console_item(mode, code, idx);
    due_reports.push_back(typed ? typed_report : forecast);
    // the spare mode, codes above DEL in any mode and ignored control codes do not count toward the run length
    if (!(mode == MODE_SPARE || code > tcw_pkg::CH_DEL ||
          (mode == tcw_pkg::MODE_PUT && code < tcw_pkg::CH_SPACE &&
           code != tcw_pkg::CH_BS && code != tcw_pkg::CH_TAB &&
           code != tcw_pkg::CH_CR && code != tcw_pkg::CH_LF)))
      items_taken++;
    @(negedge clk);
  endtask

  task automatic put_code(input logic [tcw_pkg::CODE_W-1:0] code);
    push_item(tcw_pkg::MODE_PUT, code, tcw_pkg::LOC_W'($urandom_range(0, LOC_MAX)),
              1'b0, '0);
  endtask

  task automatic write_register(input logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tcw_pkg::ATTR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == tcw_pkg::CFG_CHAR_ATTR) text_attr = value;
    else fill_attr = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random_phase(input int quota);
    int stop_at, kind, len, k, pick;
    logic [tcw_pkg::CODE_W-1:0] c;
    stop_at = items_taken + quota;
    while (items_taken < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // a line of text, now and then long enough to wrap
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 14);
        for (k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 85)
            c = tcw_pkg::CODE_W'($urandom_range(tcw_pkg::CH_SPACE, tcw_pkg::CH_DEL));
          else if (pick < 92) c = tcw_pkg::CH_TAB;
          else if (pick < 97) c = tcw_pkg::CH_BS;
          else c = tcw_pkg::CH_CR;
          put_code(c);
        end
        pick = $urandom_range(0, 99);
        if (pick < 25) put_code(tcw_pkg::CH_CR);
        if (pick < 85) put_code(tcw_pkg::CH_LF);
      end else if (kind < 62) begin
        repeat ($urandom_range(1, 8)) put_code(tcw_pkg::CH_LF);
      end else if (kind < 77) begin
        repeat ($urandom_range(1, 4))
          push_item(tcw_pkg::MODE_READ, tcw_pkg::CODE_W'($urandom_range(0, 255)),
                    ($urandom_range(0, 9) == 0)
                      ? tcw_pkg::LOC_W'($urandom_range(CELLS, LOC_MAX))
                      : tcw_pkg::LOC_W'($urandom_range(0, CELLS - 1)),
                    1'b0, '0);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 12)) put_code(tcw_pkg::CH_TAB);
      end else if (kind < 97) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 3) == 0)
            push_item(MODE_SPARE, tcw_pkg::CODE_W'($urandom_range(0, 255)),
                      tcw_pkg::LOC_W'($urandom_range(0, LOC_MAX)), 1'b0, '0);
          else
            put_code(tcw_pkg::CODE_W'($urandom_range(0, 255)));
        end
      end else begin
        push_item(tcw_pkg::MODE_CLEAR, tcw_pkg::CODE_W'($urandom_range(0, 255)),
                  tcw_pkg::LOC_W'($urandom_range(0, LOC_MAX)), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    cell_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        $error("result beat with nothing outstanding: cursor_location %0d read_data 0x%04h",
               out_cursor_location, out_read_data);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        if (out_cursor_location !== want.loc) begin
          $error("cursor_location: expected %0d, got %0d", want.loc, out_cursor_location);
          mismatches++;
        end
        if (out_read_data !== want.data) begin
          $error("read_data: expected 0x%04h, got 0x%04h", want.data, out_read_data);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int r;
    script_row_t srow;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = tcw_pkg::MODE_PUT;
    in_char_code  = '0;
    in_cell_index = '0;
    cfg_valid     = 1'b0;
    cfg_index     = tcw_pkg::CFG_CHAR_ATTR;
    cfg_data      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 86;
    for (r = 0; r < OPENING_ROWS; r++) begin
      srow = opening_script[SCRIPT_AW'(r)];
      push_item(srow.mode, srow.code, srow.idx, srow.typed, {srow.loc, srow.data});
    end
    wait_idle();
    write_register(tcw_pkg::CFG_CHAR_ATTR, 8'h00);
    write_register(tcw_pkg::CFG_BLANK_ATTR, 8'hFF);
    run_random_phase(PHASE_ITEMS);

    wait_idle();
    send_idle_pct = 86;
    recv_idle_pct = 12;
    write_register(tcw_pkg::CFG_CHAR_ATTR, 8'hFF);
    write_register(tcw_pkg::CFG_BLANK_ATTR, 8'h00);
    run_random_phase(PHASE_ITEMS);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(tcw_pkg::CFG_CHAR_ATTR, tcw_pkg::ATTR_W'($urandom_range(0, 255)));
    write_register(tcw_pkg::CFG_BLANK_ATTR, tcw_pkg::ATTR_W'($urandom_range(0, 255)));
    run_random_phase(PHASE_ITEMS);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tcw_pkg.sv
hdl/tcw_screen_ram.sv
hdl/tcw_cursor.sv
hdl/text_console_writer.sv
test/testbench.sv
